// ===== hdl/vector_normalize_to_radius_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VECTOR_NORMALIZE_TO_RADIUS_ASSERT_SVH
`define VECTOR_NORMALIZE_TO_RADIUS_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define VNR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define VNR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/vnr_pkg.sv =====
// ----------------------------------------------------------------------------
// vnr_pkg
// Widths and constants for the vector normalizer.
// ----------------------------------------------------------------------------
package vnr_pkg;
    localparam int CoordW  = 24;
    localparam int RadiusW = 23;
    localparam logic [RadiusW-1:0] RadiusReset = 23'd65536;
    localparam int MagW    = 24;   // magnitude up to 2^23
    localparam int SumW    = 50;   // sum of three squares
    localparam int RadW    = 64;   // sum shifted by 14
    localparam int LenW    = 32;   // root of a 64-bit value
    localparam int NumW    = 55;   // 2*num fits
    localparam int QW      = 56;
    localparam int PosMax  = 8388607;
    localparam int NegMax  = 8388608;
endpackage

// ===== hdl/vnr_div.sv =====
// ----------------------------------------------------------------------------
// vnr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vnr_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [vnr_pkg::QW-1:0]  i_num,
    input  logic [vnr_pkg::QW-1:0]  i_den,
    output logic                    o_valid,
    output logic [vnr_pkg::QW-1:0]  o_quot
);
    import vnr_pkg::*;

    logic [QW:0]   r_vld;
    logic [QW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [QW-1:0] r_den [QW+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_rem[0] = '0;
        r_quo[0] = i_num;
        r_den[0] = i_den;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [QW:0]   n_trial;
        logic [QW-1:0] n_sh;
        always_comb begin
            n_sh    = {r_rem[s][QW-2:0], r_quo[s][QW-1]};
            n_trial = {r_rem[s][QW-1], n_sh} - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_den[s+1] <= r_den[s];
            if (!n_trial[QW]) begin
                r_rem[s+1] <= n_trial[QW-1:0];
                r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_sh;
                r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_quo[QW];
endmodule

// ===== hdl/vector_normalize_to_radius.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_to_radius
// Scales a 3D point onto a sphere of configured radius, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// command   in         i_start, o_busy    i_vec_x, i_vec_y, i_vec_z
// result    out        o_done strobe      o_out_x/y/z, o_was_zero
// config    in         i_cfg_valid/ready  i_cfg_data (radius)
//
// One item is taken every cycle; o_busy is always low outside reset.
// Each item passes from the accepting edge through the magnitude, square and sum
// registers, the root stages (one bit per stage), the products register, the divide
// stages and the output register, which holds the result.
// Reset clears all valid bits and sets the radius to 1.0.
// The receiver cannot stall, so nothing holds the pipeline.
module vector_normalize_to_radius (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [vnr_pkg::CoordW-1:0] i_vec_x,
    input  logic signed [vnr_pkg::CoordW-1:0] i_vec_y,
    input  logic signed [vnr_pkg::CoordW-1:0] i_vec_z,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vnr_pkg::RadiusW-1:0]    i_cfg_data,
    output logic                           o_done,
    output logic signed [vnr_pkg::CoordW-1:0] o_out_x,
    output logic signed [vnr_pkg::CoordW-1:0] o_out_y,
    output logic signed [vnr_pkg::CoordW-1:0] o_out_z,
    output logic                           o_was_zero
);
    import vnr_pkg::*;

    localparam int SqrtN = LenW;

    logic [RadiusW-1:0] r_radius;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RadiusReset;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;
    assign o_busy      = !i_rst_n;

    // Stage 1: magnitudes and signs.
    logic             r1_v;
    logic [MagW-1:0]  r1_m [3];
    logic [2:0]       r1_neg;
    logic [CoordW-1:0] w_in [3];
    assign w_in[0] = i_vec_x;
    assign w_in[1] = i_vec_y;
    assign w_in[2] = i_vec_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= i_start;
        for (int k = 0; k < 3; k++) begin
            r1_neg[k] <= w_in[k][CoordW-1];
            r1_m[k]   <= w_in[k][CoordW-1] ? MagW'(-{1'b1, w_in[k]}) : MagW'(w_in[k]);
        end
    end

    // Stage 2: squares.
    logic             r2_v;
    logic [47:0]      r2_sq [3];
    logic [MagW-1:0]  r2_m [3];
    logic [2:0]       r2_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_neg <= r1_neg;
        for (int k = 0; k < 3; k++) begin
            r2_m[k]  <= r1_m[k];
            r2_sq[k] <= r1_m[k] * r1_m[k];
        end
    end

    // Stage 3: sum.
    logic             r3_v;
    logic [SumW-1:0]  r3_sum;
    logic [MagW-1:0]  r3_m [3];
    logic [2:0]       r3_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_neg <= r2_neg;
        r3_m   <= r2_m;
        r3_sum <= SumW'(r2_sq[0]) + SumW'(r2_sq[1]) + SumW'(r2_sq[2]);
    end

    // Root pipeline: one result bit per stage, non-restoring-free classic form.
    logic             s_v   [SqrtN+1];
    logic [RadW-1:0]  s_rem [SqrtN+1];
    logic [LenW-1:0]  s_res [SqrtN+1];
    logic [MagW-1:0]  s_m   [SqrtN+1][3];
    logic [2:0]       s_neg [SqrtN+1];
    logic             s_zero[SqrtN+1];

    always_comb begin
        s_v[0]    = r3_v;
        s_rem[0]  = {r3_sum, 14'd0};
        s_res[0]  = '0;
        s_m[0]    = r3_m;
        s_neg[0]  = r3_neg;
        s_zero[0] = (r3_sum == '0);
    end

    for (genvar s = 0; s < SqrtN; s++) begin : g_sqrt
        localparam int Bt = SqrtN - 1 - s;
        localparam int Sh = 2 * Bt;
        logic [RadW+1:0] n_trial;
        logic [RadW+1:0] n_cand;
        // Trial subtrahend is res * 2^(b+1) + 2^(2b) for result bit b.
        always_comb begin
            n_cand  = ({2'b0, 32'd0, s_res[s]} << (Bt + 1)) + ((RadW+2)'(1) << Sh);
            n_trial = {2'b0, s_rem[s]} - n_cand;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) s_v[s+1] <= 1'b0;
            else s_v[s+1] <= s_v[s];
            s_m[s+1]    <= s_m[s];
            s_neg[s+1]  <= s_neg[s];
            s_zero[s+1] <= s_zero[s];
            if (!n_trial[RadW+1]) begin
                s_rem[s+1] <= n_trial[RadW-1:0];
                s_res[s+1] <= s_res[s] | (LenW'(1) << (SqrtN - 1 - s));
            end else begin
                s_rem[s+1] <= s_rem[s];
                s_res[s+1] <= s_res[s];
            end
        end
    end

    // Products |c| * radius.
    logic             p1_v, p1_zero;
    logic [46:0]      p1_prod [3];
    logic [LenW-1:0]  p1_len;
    logic [2:0]       p1_neg;
    logic [RadiusW-1:0] p1_rad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) p1_v <= 1'b0;
        else p1_v <= s_v[SqrtN];
        p1_zero <= s_zero[SqrtN];
        p1_len  <= s_res[SqrtN];
        p1_neg  <= s_neg[SqrtN];
        p1_rad  <= r_radius;
        for (int k = 0; k < 3; k++) p1_prod[k] <= s_m[SqrtN][k] * r_radius;
    end

    // Divider operands: (prod * 256 + len) / (2 * len).
    logic [QW-1:0] w_num [3];
    logic [QW-1:0] w_den;
    assign w_den = QW'({p1_len, 1'b0});
    for (genvar k = 0; k < 3; k++) begin : g_num
        assign w_num[k] = ({QW'(p1_prod[k]) << 8}) + QW'(p1_len);
    end

    logic [QW-1:0] w_q [3];
    logic [2:0]    w_qv;
    for (genvar k = 0; k < 3; k++) begin : g_div
        vnr_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p1_v),
            .i_num(w_num[k]), .i_den(w_den),
            .o_valid(w_qv[k]), .o_quot(w_q[k])
        );
    end

    // Side pipe for sign, zero flag and radius alongside the divider.
    logic [2:0]         d_neg  [QW+1];
    logic               d_zero [QW+1];
    logic [RadiusW-1:0] d_rad  [QW+1];
    always_comb begin
        d_neg[0] = p1_neg; d_zero[0] = p1_zero; d_rad[0] = p1_rad;
    end
    for (genvar s = 0; s < QW; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            d_neg[s+1]  <= d_neg[s];
            d_zero[s+1] <= d_zero[s];
            d_rad[s+1]  <= d_rad[s];
        end
    end

    function automatic logic [CoordW-1:0] sat(input logic [QW-1:0] q, input logic neg);
        logic [CoordW-1:0] r;
        if (neg) begin
            if (q >= QW'(NegMax)) r = {1'b1, {(CoordW-1){1'b0}}};
            else r = CoordW'(-q[CoordW-1:0]);
        end else begin
            if (q > QW'(PosMax)) r = {1'b0, {(CoordW-1){1'b1}}};
            else r = q[CoordW-1:0];
        end
        return r;
    endfunction

    logic r_done, r_zero;
    logic [CoordW-1:0] r_o [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= w_qv[0];
        r_zero <= d_zero[QW];
        for (int k = 0; k < 3; k++)
            r_o[k] <= d_zero[QW] ? CoordW'(d_rad[QW]) : sat(w_q[k], d_neg[QW][k]);
    end

    assign o_done     = r_done;
    assign o_was_zero = r_zero;
    assign o_out_x    = r_o[0];
    assign o_out_y    = r_o[1];
    assign o_out_z    = r_o[2];
endmodule

// ===== hdl/vnr_checker.sv =====
// ----------------------------------------------------------------------------
// vnr_checker
// Port-level checks on the vector normalizer.
// ----------------------------------------------------------------------------
`include "vector_normalize_to_radius_assert.svh"
module vnr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_cfg_ready,
    input logic        o_done,
    input logic        o_was_zero,
    input logic [23:0] o_out_x,
    input logic [23:0] o_out_y
);
    // A zero point gives equal coordinates.
    `VNR_ASSERT_IMPL(a_zero_eq, i_clk, i_rst_n, o_done && o_was_zero, o_out_x == o_out_y)
    // The block never holds off commands once out of reset.
    `VNR_ASSERT_IMPL(a_not_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    // Configuration is always taken.
    `VNR_ASSERT_NEXT(a_cfg_rdy, i_clk, i_rst_n, 1'b1, o_cfg_ready)
endmodule

bind vector_normalize_to_radius vnr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy), .o_cfg_ready(o_cfg_ready),
    .o_done(o_done), .o_was_zero(o_was_zero), .o_out_x(o_out_x), .o_out_y(o_out_y)
);
